// File: rtl/iepb_pkg.sv
// ----------------------------------------------------------------------------
// iepb_pkg
// Types and constants of the ICMP echo packet builder.
// ----------------------------------------------------------------------------
package iepb_pkg;

    typedef enum logic [2:0] {
        S_IN,
        S_ERR,
        S_SUM,
        S_FOLD,
        S_HDR,
        S_RD,
        S_PAY
    } t_state;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ODD  = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    localparam logic [7:0] REG_TYPE = 8'd0;
    localparam logic [7:0] REG_CODE = 8'd1;

    localparam logic [7:0]  TYPE_RESET = 8'd8;
    localparam logic [7:0]  CODE_RESET = 8'd0;
    localparam logic [15:0] ID_RESET   = 16'd1;
    localparam logic [15:0] SEQ_RESET  = 16'd0;

    localparam logic [1:0] HDR_TYPE = 2'd0;
    localparam logic [1:0] HDR_CSUM = 2'd1;
    localparam logic [1:0] HDR_ID   = 2'd2;
    localparam logic [1:0] HDR_SEQ  = 2'd3;

endpackage

// File: rtl/icmp_echo_packet_builder_core.sv
// ----------------------------------------------------------------------------
// icmp_echo_packet_builder_core
// Buffers an ICMP payload and emits the echo packet as 16-bit words.
//
// Channel  Direction  Transaction
// s        in         tdata = payload_byte [7:0], tlast = end_of_message
// m        out        tdata = packet_word [15:0], tlast = final_word,
//                     tuser = status [1:0]
// cfg      in         index = register index, data = register value
//
// Each payload byte is written to the word memory as its pair completes.
// After the last byte the sum takes in the header (S_SUM) and is folded
// (S_FOLD); the header words go out from S_HDR, each payload word is read
// (S_RD) then sent (S_PAY); an error result is one zero word (S_ERR).
// No byte is accepted from the last byte until the final word is loaded
// into the output register. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module icmp_echo_packet_builder_core #(
    parameter int MAX_PAYLOAD_BYTES = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] payload_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] packet_word
    output logic        o_m_tlast,
    output logic [1:0]  o_m_tuser,   // [1:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int CW  = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int WD  = MAX_PAYLOAD_BYTES / 2;
    localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
    localparam int SW  = 16 + $clog2(WD + 3);

    iepb_pkg::t_state r_state, n_state;
    logic [7:0]    r_type, n_type;
    logic [7:0]    r_code, n_code;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [7:0]    r_hold, n_hold;
    logic [SW-1:0] r_sum, n_sum;
    logic [15:0]   r_id, n_id;
    logic [15:0]   r_seq, n_seq;
    logic [15:0]   r_csum, n_csum;
    logic [1:0]    r_hix, n_hix;
    logic [CW-2:0] r_wix, n_wix;
    logic [1:0]    r_err, n_err;
    logic          r_out_valid, n_out_valid;
    logic [15:0]   r_out_word, n_out_word;
    logic          r_out_final, n_out_final;
    logic [1:0]    r_out_status, n_out_status;
    logic [15:0]   r_rdata;

    logic [15:0] mem [WD];

    logic          w_in_acc;
    logic          w_out_free;
    logic          w_full;
    logic          w_load;
    logic [CW-2:0] w_words;
    logic [15:0]   w_pair;
    logic          w_mem_we;
    logic [16:0]   w_fold1;
    logic [15:0]   w_fold2;

    assign o_s_tready  = (r_state == iepb_pkg::S_IN);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_word;
    assign o_m_tlast   = r_out_final;
    assign o_m_tuser   = r_out_status;

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_full     = (r_count == CW'(MAX_PAYLOAD_BYTES));
    assign w_words    = r_count[CW-1:1];
    assign w_pair     = {r_hold, i_s_tdata};
    assign w_mem_we   = w_in_acc && !w_full && r_count[0];
    assign w_fold1    = {1'b0, r_sum[15:0]} + 17'(r_sum[SW-1:16]);
    assign w_fold2    = w_fold1[15:0] + 16'(w_fold1[16]);

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_words[WAW-1:0]] <= w_pair;
        end
        r_rdata <= mem[r_wix[WAW-1:0]];
    end

    always_comb begin
        n_state      = r_state;
        n_type       = r_type;
        n_code       = r_code;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_hold       = r_hold;
        n_sum        = r_sum;
        n_id         = r_id;
        n_seq        = r_seq;
        n_csum       = r_csum;
        n_hix        = r_hix;
        n_wix        = r_wix;
        n_err        = r_err;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_word   = r_out_word;
        n_out_final  = r_out_final;
        n_out_status = r_out_status;
        w_load       = 1'b0;

        if (i_cfg_valid) begin
            if (i_cfg_index == iepb_pkg::REG_TYPE) begin
                n_type = i_cfg_data;
            end else if (i_cfg_index == iepb_pkg::REG_CODE) begin
                n_code = i_cfg_data;
            end
        end

        unique case (r_state)
            iepb_pkg::S_IN: begin
                if (w_in_acc) begin
                    if (!w_full) begin
                        if (r_count[0]) begin
                            n_sum = r_sum + SW'(w_pair);
                        end else begin
                            n_hold = i_s_tdata;
                        end
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_tlast) begin
                        priority if (r_ovf || w_full) begin
                            n_err   = iepb_pkg::ST_LONG;
                            n_state = iepb_pkg::S_ERR;
                        end else if (!r_count[0]) begin
                            n_err   = iepb_pkg::ST_ODD;
                            n_state = iepb_pkg::S_ERR;
                        end else begin
                            n_state = iepb_pkg::S_SUM;
                        end
                    end
                end
            end
            iepb_pkg::S_ERR: begin
                if (w_out_free) begin
                    w_load       = 1'b1;
                    n_out_word   = 16'd0;
                    n_out_final  = 1'b1;
                    n_out_status = r_err;
                    n_state      = iepb_pkg::S_IN;
                end
            end
            iepb_pkg::S_SUM: begin
                n_sum   = r_sum + SW'({r_type, r_code}) + SW'(r_id) + SW'(r_seq);
                n_hix   = iepb_pkg::HDR_TYPE;
                n_wix   = '0;
                n_state = iepb_pkg::S_FOLD;
            end
            iepb_pkg::S_FOLD: begin
                n_csum  = ~w_fold2;
                n_state = iepb_pkg::S_HDR;
            end
            iepb_pkg::S_HDR: begin
                if (w_out_free) begin
                    w_load       = 1'b1;
                    n_out_status = iepb_pkg::ST_OK;
                    n_out_final  = 1'b0;
                    unique case (r_hix)
                        iepb_pkg::HDR_TYPE: n_out_word = {r_type, r_code};
                        iepb_pkg::HDR_CSUM: n_out_word = r_csum;
                        iepb_pkg::HDR_ID:   n_out_word = r_id;
                        iepb_pkg::HDR_SEQ:  n_out_word = r_seq;
                        default:            n_out_word = 16'd0;
                    endcase
                    if (r_hix == iepb_pkg::HDR_SEQ) begin
                        if (w_words == '0) begin
                            n_out_final = 1'b1;
                            n_state     = iepb_pkg::S_IN;
                        end else begin
                            n_state = iepb_pkg::S_RD;
                        end
                    end else begin
                        n_hix = r_hix + 2'd1;
                    end
                end
            end
            iepb_pkg::S_RD: begin
                n_state = iepb_pkg::S_PAY;
            end
            iepb_pkg::S_PAY: begin
                if (w_out_free) begin
                    w_load       = 1'b1;
                    n_out_word   = r_rdata;
                    n_out_status = iepb_pkg::ST_OK;
                    n_out_final  = ((r_wix + (CW-1)'(1)) == w_words);
                    if (n_out_final) begin
                        n_state = iepb_pkg::S_IN;
                    end else begin
                        n_wix   = r_wix + (CW-1)'(1);
                        n_state = iepb_pkg::S_RD;
                    end
                end
            end
            default: begin
                n_state = iepb_pkg::S_IN;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
            if (n_out_final) begin
                n_id    = r_id + 16'd1;
                n_seq   = r_seq + 16'd1;
                n_count = '0;
                n_ovf   = 1'b0;
                n_sum   = '0;
                n_hold  = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iepb_pkg::S_IN;
            r_type      <= iepb_pkg::TYPE_RESET;
            r_code      <= iepb_pkg::CODE_RESET;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_hold      <= 8'd0;
            r_sum       <= '0;
            r_id        <= iepb_pkg::ID_RESET;
            r_seq       <= iepb_pkg::SEQ_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_type      <= n_type;
            r_code      <= n_code;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_hold      <= n_hold;
            r_sum       <= n_sum;
            r_id        <= n_id;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
        r_csum       <= n_csum;
        r_hix        <= n_hix;
        r_wix        <= n_wix;
        r_err        <= n_err;
        r_out_word   <= n_out_word;
        r_out_final  <= n_out_final;
        r_out_status <= n_out_status;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PAYLOAD_BYTES))
        else $error("byte count exceeds buffer depth");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != iepb_pkg::ST_OK) |-> (r_out_final && r_out_word == 16'd0))
        else $error("error result is not a single zero word");

    a_clear_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_out_final) |=> (r_count == '0 && !r_ovf && r_state == iepb_pkg::S_IN))
        else $error("message state not cleared after final word");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iepb_pkg::S_PAY) |-> (r_wix < w_words))
        else $error("payload read beyond buffered words");

endmodule
